// ----- rtl/core/dec_pkg.sv -----
`timescale 1ns / 1ps

package dec_pkg;

  localparam int FRAC_BITS = 4;
  // 0.1 px in the fixed-point grid, rounded half up
  localparam int C01 = ((1 << FRAC_BITS) + 5) / 10;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam int SQ_STEPS = 12;
  localparam int PDIV_STEPS = 12;
  localparam int VDIV_STEPS = 18;
  localparam int LAT = SQ_STEPS + 2 + PDIV_STEPS;
  localparam int VEL_TAP = LAT - VDIV_STEPS - 5;

  typedef struct packed {
    logic               skip_pair;
    logic signed [15:0] pos_a_x;
    logic signed [15:0] pos_a_y;
    logic signed [15:0] pos_b_x;
    logic signed [15:0] pos_b_y;
    logic signed [15:0] vel_a_x;
    logic signed [15:0] vel_a_y;
    logic signed [15:0] vel_b_x;
    logic signed [15:0] vel_b_y;
    logic [11:0]        radius_sum;
    logic [15:0]        mass_a;
    logic [15:0]        mass_b;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] new_pos_a_x;
    logic signed [15:0] new_pos_a_y;
    logic signed [15:0] new_pos_b_x;
    logic signed [15:0] new_pos_b_y;
    logic signed [15:0] new_vel_a_x;
    logic signed [15:0] new_vel_a_y;
    logic signed [15:0] new_vel_b_x;
    logic signed [15:0] new_vel_b_y;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    in_t                pay;
    logic               hit;
    logic signed [12:0] dx;
    logic signed [12:0] dy;
    logic signed [16:0] dvx;
    logic signed [16:0] dvy;
    logic [16:0]        msum;
    logic [23:0]        d2;
  } rec_t;

endpackage

// ----- rtl/core/dec_front.sv -----
`timescale 1ns / 1ps

module dec_front import dec_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  in_t  in_data,
  output logic rec_valid,
  output rec_t rec_data,
  input  logic rec_full
);

  logic               en;
  logic [2:0]         v_r;
  in_t                p1_r, p2_r;
  logic signed [16:0] dx1_r, dy1_r, dvx1_r, dvy1_r;
  logic signed [16:0] dx2_r, dy2_r, dvx2_r, dvy2_r;
  logic [16:0]        ms1_r, ms2_r;
  logic [23:0]        rs2_1_r, rs2_2_r;
  logic [32:0]        dxx_r, dyy_r;
  rec_t               rec_r;

  logic signed [16:0] dx_c, dy_c, dvx_c, dvy_c;
  logic [23:0]        rs2_c;
  logic signed [33:0] sqx, sqy;
  logic [33:0]        d2_c;

  assign en = !(v_r[2] && rec_full);
  assign full = !en;

  assign dx_c = {in_data.pos_b_x[15], in_data.pos_b_x} - {in_data.pos_a_x[15], in_data.pos_a_x};
  assign dy_c = {in_data.pos_b_y[15], in_data.pos_b_y} - {in_data.pos_a_y[15], in_data.pos_a_y};
  assign dvx_c = {in_data.vel_b_x[15], in_data.vel_b_x} - {in_data.vel_a_x[15], in_data.vel_a_x};
  assign dvy_c = {in_data.vel_b_y[15], in_data.vel_b_y} - {in_data.vel_a_y[15], in_data.vel_a_y};
  assign rs2_c = in_data.radius_sum * in_data.radius_sum;

  assign sqx = dx1_r * dx1_r;
  assign sqy = dy1_r * dy1_r;

  assign d2_c = {1'b0, dxx_r} + {1'b0, dyy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= in_data;
      dx1_r   <= dx_c;
      dy1_r   <= dy_c;
      dvx1_r  <= dvx_c;
      dvy1_r  <= dvy_c;
      ms1_r   <= {1'b0, in_data.mass_a} + {1'b0, in_data.mass_b};
      rs2_1_r <= rs2_c;

      p2_r    <= p1_r;
      dx2_r   <= dx1_r;
      dy2_r   <= dy1_r;
      dvx2_r  <= dvx1_r;
      dvy2_r  <= dvy1_r;
      ms2_r   <= ms1_r;
      rs2_2_r <= rs2_1_r;
      dxx_r   <= sqx[32:0];
      dyy_r   <= sqy[32:0];

      rec_r.pay  <= p2_r;
      rec_r.hit  <= !p2_r.skip_pair && (d2_c != '0) && (d2_c < {10'b0, rs2_2_r});
      rec_r.dx   <= dx2_r[12:0];
      rec_r.dy   <= dy2_r[12:0];
      rec_r.dvx  <= dvx2_r;
      rec_r.dvy  <= dvy2_r;
      rec_r.msum <= ms2_r;
      rec_r.d2   <= d2_c[23:0];
    end
  end

  assign rec_valid = v_r[2];
  assign rec_data = rec_r;

endmodule

// ----- rtl/core/dec_queue.sv -----
`timescale 1ns / 1ps

module dec_queue import dec_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t wdata,
  output logic full,
  input  logic pop,
  output rec_t rdata,
  output logic empty
);

  rec_t         mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;
  logic           do_push, do_pop;

  assign full = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

endmodule

// ----- rtl/core/dec_back.sv -----
`timescale 1ns / 1ps

module dec_back import dec_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  output logic q_pop,
  input  rec_t q_data,
  input  logic pop,
  output logic empty,
  output out_t out_data
);

  function automatic logic [11:0] mag13(input logic signed [12:0] v);
    logic signed [12:0] n;
    n = -v;
    return v[12] ? n[11:0] : v[11:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sh7fff;
    else if (v < -20'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

  logic           en;
  logic [LAT-1:0] vld_r;
  rec_t           ctx_r [LAT];

  // output queue
  out_t oq_mem_r [2];
  logic oq_wp_r, oq_rp_r;
  logic [1:0] oq_cnt_r;
  logic oq_full, oq_push, oq_pop;

  assign oq_full = (oq_cnt_r == 2'd2);
  assign en = !(vld_r[LAT-1] && oq_full);
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= q_data;
      for (int k = 1; k < LAT; k++) ctx_r[k] <= ctx_r[k-1];
    end
  end

  // integer square root, one result bit per stage
  logic [23:0] sq_rem_r [SQ_STEPS];
  logic [23:0] sq_res_r [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    localparam logic [23:0] BIT = 24'(1) << (2 * (SQ_STEPS - 1 - j));
    logic [23:0] rem_i, res_i, rem_o, res_o;
    logic [24:0] trial;
    if (j == 0) begin : g_first
      assign rem_i = q_data.d2;
      assign res_i = '0;
    end else begin : g_next
      assign rem_i = sq_rem_r[j-1];
      assign res_i = sq_res_r[j-1];
    end
    assign trial = {1'b0, res_i} + {1'b0, BIT};
    always_comb begin
      if ({1'b0, rem_i} >= trial) begin
        rem_o = rem_i - trial[23:0];
        res_o = (res_i >> 1) + BIT;
      end else begin
        rem_o = rem_i;
        res_o = res_i >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[j] <= rem_o;
        sq_res_r[j] <= res_o;
      end
    end
  end

  // separation: overlap, then |d| * ov / (2 * dist)
  logic [12:0] ov_r, pd_r, pden_r;
  logic [24:0] pnx_r, pny_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ov_r   <= 13'({1'b0, ctx_r[SQ_STEPS-1].pay.radius_sum}) + 13'(C01)
                - {1'b0, sq_res_r[SQ_STEPS-1][11:0]};
      pd_r   <= {sq_res_r[SQ_STEPS-1][11:0], 1'b0};
      pnx_r  <= mag13(ctx_r[SQ_STEPS].dx) * ov_r;
      pny_r  <= mag13(ctx_r[SQ_STEPS].dy) * ov_r;
      pden_r <= pd_r;
    end
  end

  logic [24:0] pxr_r [PDIV_STEPS];
  logic [24:0] pyr_r [PDIV_STEPS];
  logic [11:0] pxq_r [PDIV_STEPS];
  logic [11:0] pyq_r [PDIV_STEPS];
  logic [12:0] pdn_r [PDIV_STEPS];

  for (genvar m = 0; m < PDIV_STEPS; m++) begin : g_pdiv
    localparam int SH = PDIV_STEPS - 1 - m;
    logic [24:0] xr_i, yr_i, dsh;
    logic [11:0] xq_i, yq_i;
    logic [12:0] dn_i;
    if (m == 0) begin : g_first
      assign xr_i = pnx_r;
      assign yr_i = pny_r;
      assign xq_i = '0;
      assign yq_i = '0;
      assign dn_i = pden_r;
    end else begin : g_next
      assign xr_i = pxr_r[m-1];
      assign yr_i = pyr_r[m-1];
      assign xq_i = pxq_r[m-1];
      assign yq_i = pyq_r[m-1];
      assign dn_i = pdn_r[m-1];
    end
    assign dsh = 25'(dn_i) << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        pdn_r[m] <= dn_i;
        if (xr_i >= dsh) begin
          pxr_r[m] <= xr_i - dsh;
          pxq_r[m] <= xq_i | (12'(1) << SH);
        end else begin
          pxr_r[m] <= xr_i;
          pxq_r[m] <= xq_i;
        end
        if (yr_i >= dsh) begin
          pyr_r[m] <= yr_i - dsh;
          pyq_r[m] <= yq_i | (12'(1) << SH);
        end else begin
          pyr_r[m] <= yr_i;
          pyq_r[m] <= yq_i;
        end
      end
    end
  end

  // velocity exchange: 2*m*p*d / (M*d2) per component
  logic signed [29:0] vpx_c, vpy_c;
  logic signed [29:0] vpx_r, vpy_r;
  logic [40:0]        vden4_r, vden5_r, vden6_r, vden7_r;
  logic signed [30:0] vp_c;
  logic [30:0]        vpm_r;
  logic               vps5_r, vps6_r;
  logic [46:0]        vma_r, vmb_r;
  logic [58:0]        nax_c, nay_c, nbx_c, nby_c;
  logic [59:0]        vn7_r [4];
  logic [1:0]         vs7_r;

  assign vpx_c = ctx_r[VEL_TAP].dvx * ctx_r[VEL_TAP].dx;
  assign vpy_c = ctx_r[VEL_TAP].dvy * ctx_r[VEL_TAP].dy;
  assign vp_c = {vpx_r[29], vpx_r} + {vpy_r[29], vpy_r};
  assign nax_c = vma_r * mag13(ctx_r[VEL_TAP+3].dx);
  assign nay_c = vma_r * mag13(ctx_r[VEL_TAP+3].dy);
  assign nbx_c = vmb_r * mag13(ctx_r[VEL_TAP+3].dx);
  assign nby_c = vmb_r * mag13(ctx_r[VEL_TAP+3].dy);

  always_ff @(posedge clk) begin
    if (en) begin
      vpx_r   <= vpx_c;
      vpy_r   <= vpy_c;
      vden4_r <= ctx_r[VEL_TAP].msum * ctx_r[VEL_TAP].d2;

      vpm_r   <= vp_c[30] ? 31'(-vp_c) : 31'(vp_c);
      vps5_r  <= vp_c[30];
      vden5_r <= vden4_r;

      vma_r   <= ctx_r[VEL_TAP+2].pay.mass_b * vpm_r;
      vmb_r   <= ctx_r[VEL_TAP+2].pay.mass_a * vpm_r;
      vps6_r  <= vps5_r;
      vden6_r <= vden5_r;

      vn7_r[0] <= {nax_c, 1'b0};
      vn7_r[1] <= {nay_c, 1'b0};
      vn7_r[2] <= {nbx_c, 1'b0};
      vn7_r[3] <= {nby_c, 1'b0};
      vs7_r    <= {vps6_r ^ ctx_r[VEL_TAP+3].dy[12], vps6_r ^ ctx_r[VEL_TAP+3].dx[12]};
      vden7_r  <= vden6_r;
    end
  end

  logic [59:0] vr_r [VDIV_STEPS][4];
  logic [17:0] vq_r [VDIV_STEPS][4];
  logic [40:0] vdn_r [VDIV_STEPS];
  logic [1:0]  vsg_r [VDIV_STEPS];

  for (genvar m = 0; m < VDIV_STEPS; m++) begin : g_vdiv
    localparam int SH = VDIV_STEPS - 1 - m;
    logic [59:0] dsh;
    logic [40:0] dn_i;
    logic [1:0]  sg_i;
    if (m == 0) begin : g_first
      assign dn_i = vden7_r;
      assign sg_i = vs7_r;
    end else begin : g_next
      assign dn_i = vdn_r[m-1];
      assign sg_i = vsg_r[m-1];
    end
    assign dsh = 60'(dn_i) << SH;
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [59:0] r_i;
      logic [17:0] q_i;
      if (m == 0) begin : g_first
        assign r_i = vn7_r[l];
        assign q_i = '0;
      end else begin : g_next
        assign r_i = vr_r[m-1][l];
        assign q_i = vq_r[m-1][l];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          if (r_i >= dsh) begin
            vr_r[m][l] <= r_i - dsh;
            vq_r[m][l] <= q_i | (18'(1) << SH);
          end else begin
            vr_r[m][l] <= r_i;
            vq_r[m][l] <= q_i;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        vdn_r[m] <= dn_i;
        vsg_r[m] <= sg_i;
      end
    end
  end

  // final combine and saturation
  rec_t               cf;
  out_t               res_c;
  logic signed [19:0] shx, shy, dvax, dvay, dvbx, dvby;
  logic [1:0]         sgf;

  assign cf = ctx_r[LAT-1];
  assign sgf = vsg_r[VDIV_STEPS-1];

  always_comb begin
    shx  = cf.dx[12] ? -$signed({8'b0, pxq_r[PDIV_STEPS-1]})
                     : $signed({8'b0, pxq_r[PDIV_STEPS-1]});
    shy  = cf.dy[12] ? -$signed({8'b0, pyq_r[PDIV_STEPS-1]})
                     : $signed({8'b0, pyq_r[PDIV_STEPS-1]});
    dvax = sgf[0] ? -$signed({2'b0, vq_r[VDIV_STEPS-1][0]})
                  : $signed({2'b0, vq_r[VDIV_STEPS-1][0]});
    dvay = sgf[1] ? -$signed({2'b0, vq_r[VDIV_STEPS-1][1]})
                  : $signed({2'b0, vq_r[VDIV_STEPS-1][1]});
    dvbx = sgf[0] ? -$signed({2'b0, vq_r[VDIV_STEPS-1][2]})
                  : $signed({2'b0, vq_r[VDIV_STEPS-1][2]});
    dvby = sgf[1] ? -$signed({2'b0, vq_r[VDIV_STEPS-1][3]})
                  : $signed({2'b0, vq_r[VDIV_STEPS-1][3]});

    res_c.hit         = cf.hit;
    res_c.new_pos_a_x = cf.pay.pos_a_x;
    res_c.new_pos_a_y = cf.pay.pos_a_y;
    res_c.new_pos_b_x = cf.pay.pos_b_x;
    res_c.new_pos_b_y = cf.pay.pos_b_y;
    res_c.new_vel_a_x = cf.pay.vel_a_x;
    res_c.new_vel_a_y = cf.pay.vel_a_y;
    res_c.new_vel_b_x = cf.pay.vel_b_x;
    res_c.new_vel_b_y = cf.pay.vel_b_y;
    if (cf.hit) begin
      res_c.new_pos_a_x = sat16(20'(cf.pay.pos_a_x) - shx);
      res_c.new_pos_a_y = sat16(20'(cf.pay.pos_a_y) - shy);
      res_c.new_pos_b_x = sat16(20'(cf.pay.pos_b_x) + shx);
      res_c.new_pos_b_y = sat16(20'(cf.pay.pos_b_y) + shy);
      // both masses zero leaves the velocities alone
      if (cf.msum != '0) begin
        res_c.new_vel_a_x = sat16(20'(cf.pay.vel_a_x) + dvax);
        res_c.new_vel_a_y = sat16(20'(cf.pay.vel_a_y) + dvay);
        res_c.new_vel_b_x = sat16(20'(cf.pay.vel_b_x) - dvbx);
        res_c.new_vel_b_y = sat16(20'(cf.pay.vel_b_y) - dvby);
      end
    end
  end

  assign oq_push = vld_r[LAT-1] && !oq_full;
  assign empty = (oq_cnt_r == 2'd0);
  assign oq_pop = pop && !empty;
  assign out_data = oq_mem_r[oq_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (oq_push) oq_wp_r <= !oq_wp_r;
      if (oq_pop) oq_rp_r <= !oq_rp_r;
      if (oq_push && !oq_pop) oq_cnt_r <= oq_cnt_r + 2'd1;
      else if (oq_pop && !oq_push) oq_cnt_r <= oq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) oq_mem_r[oq_wp_r] <= res_c;
  end

endmodule

// ----- rtl/core/disc_elastic_collision_top.sv -----
`timescale 1ns / 1ps

// Elastic collision of two discs in fixed point, one pair per clock. A pair
// pushed while full is low takes 3 front stages (difference, squares, hit
// test), passes through a 4-entry queue (where it waits only while the back
// end is stalled), then goes through 26 back stages: a 12-step square root and
// a 12-step divider for the separation, and in parallel four 18-step dividers
// for the velocity exchange. A new pair is taken every cycle as long as
// results are popped. Stalls on the result side freeze the back pipeline,
// fill the queue, then raise full.

module disc_elastic_collision_top import dec_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  in_t  in_data,
  input  logic pop,
  output logic empty,
  output out_t out_data
);

  logic rec_valid, q_full, q_empty, q_pop;
  rec_t rec_data, q_data;

  dec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .rec_valid (rec_valid),
    .rec_data  (rec_data),
    .rec_full  (q_full)
  );

  dec_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_valid),
    .wdata (rec_data),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  dec_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_data   (q_data),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule
